@@ sv/trm_pkg.sv @@
package trm_pkg;

  // configuration port geometry
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // arithmetic constants
  localparam logic [31:0] HOUR_US    = 32'd3600000000;
  localparam logic [31:0] ROUND_HALF = 32'd2048;
  localparam logic [5:0]  MUL_STEPS  = 6'd16;
  localparam logic [5:0]  DIV_STEPS  = 6'd49;

  // register reset values
  localparam logic        RST_ENABLE       = 1'b1;
  localparam logic [19:0] RST_DEBOUNCE_US  = 20'd5000;
  localparam logic [15:0] RST_MM_PER_TIP   = 16'd18311;
  localparam logic [15:0] RST_RATE_SCALE   = 16'd4096;
  localparam logic [15:0] RST_TOTAL_SCALE  = 16'd4096;

  typedef enum logic [1:0] {
    MODE_TIP   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_DEBOUNCE_US  = 3'd1,
    REG_MM_PER_TIP   = 3'd2,
    REG_RATE_SCALE   = 3'd3,
    REG_RATE_OFFSET  = 3'd4,
    REG_TOTAL_SCALE  = 3'd5,
    REG_TOTAL_OFFSET = 3'd6
  } reg_idx_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } mdu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT_RAW,
    ST_TOT_CAL,
    ST_TOT_FIX,
    ST_NUM,
    ST_DIV,
    ST_RATE_CAL,
    ST_RATE_FIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               enable;
    logic [19:0]        debounce_us;
    logic [15:0]        mm_per_tip;
    logic [15:0]        rate_scale;
    logic signed [31:0] rate_offset;
    logic [15:0]        total_scale;
    logic signed [31:0] total_offset;
  } cfg_t;

  typedef struct packed {
    logic        start;
    mdu_op_t     op;
    logic [48:0] a;
    logic [31:0] b;
    logic [31:0] init;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

endpackage

@@ sv/trm_ifs.sv @@
// input channel: one request per item
interface trm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_us;

  modport source (output valid, mode, now_us, input ready);
  modport sink   (input valid, mode, now_us, output ready);
endinterface

// result channel
interface trm_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] rate_mmh;
  logic signed [47:0] depth_mm;

  modport source (output valid, rate_mmh, depth_mm, input ready);
  modport sink   (input valid, rate_mmh, depth_mm, output ready);
endinterface

@@ sv/trm_regs.sv @@
module trm_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trm_pkg::ADDR_W-1:0]   paddr,
  input  logic [trm_pkg::DATA_W-1:0]   pwdata,
  output logic [trm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output trm_pkg::cfg_t                cfg
);
  import trm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:       cfg_nxt.enable       = pwdata[0];
        REG_DEBOUNCE_US:  cfg_nxt.debounce_us  = pwdata[19:0];
        REG_MM_PER_TIP:   cfg_nxt.mm_per_tip   = pwdata[15:0];
        REG_RATE_SCALE:   cfg_nxt.rate_scale   = pwdata[15:0];
        REG_RATE_OFFSET:  cfg_nxt.rate_offset  = pwdata;
        REG_TOTAL_SCALE:  cfg_nxt.total_scale  = pwdata[15:0];
        REG_TOTAL_OFFSET: cfg_nxt.total_offset = pwdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= RST_ENABLE;
      cfg_r.debounce_us  <= RST_DEBOUNCE_US;
      cfg_r.mm_per_tip   <= RST_MM_PER_TIP;
      cfg_r.rate_scale   <= RST_RATE_SCALE;
      cfg_r.rate_offset  <= '0;
      cfg_r.total_scale  <= RST_TOTAL_SCALE;
      cfg_r.total_offset <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ENABLE:       prdata = {31'd0, cfg_r.enable};
      REG_DEBOUNCE_US:  prdata = {12'd0, cfg_r.debounce_us};
      REG_MM_PER_TIP:   prdata = {16'd0, cfg_r.mm_per_tip};
      REG_RATE_SCALE:   prdata = {16'd0, cfg_r.rate_scale};
      REG_RATE_OFFSET:  prdata = cfg_r.rate_offset;
      REG_TOTAL_SCALE:  prdata = {16'd0, cfg_r.total_scale};
      REG_TOTAL_OFFSET: prdata = cfg_r.total_offset;
      default:          prdata = '0;
    endcase
  end

endmodule

@@ sv/trm_mdu.sv @@
module trm_mdu (
  input  logic              clk,
  input  logic              rst_n,
  input  trm_pkg::mdu_req_t req,
  output trm_pkg::mdu_sts_t sts,
  output logic [63:0]       res
);
  import trm_pkg::*;

  mdu_op_t     op_r;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] work_r, work_nxt;
  logic [31:0] opb_r, opb_nxt;
  logic [5:0]  count_r, count_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  logic [63:0] add_a, add_b;
  logic        add_c;
  logic [64:0] sum;
  logic [63:0] shifted;

  // shared adder: accumulate for multiply, trial subtract for divide
  assign shifted = {acc_r[62:0], work_r[48]};

  always_comb begin
    if (op_r == OP_DIV) begin
      add_a = shifted;
      add_b = ~{32'd0, opb_r};
      add_c = 1'b1;
    end else begin
      add_a = acc_r;
      add_b = opb_r[0] ? work_r : 64'd0;
      add_c = 1'b0;
    end
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_c};

  // step control
  always_comb begin
    acc_nxt   = acc_r;
    work_nxt  = work_r;
    opb_nxt   = opb_r;
    count_nxt = count_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (busy_r) begin
      if (op_r == OP_DIV) begin
        acc_nxt  = sum[64] ? sum[63:0] : shifted;
        work_nxt = {work_r[62:0], sum[64]};
      end else begin
        acc_nxt  = sum[63:0];
        work_nxt = {work_r[62:0], 1'b0};
        opb_nxt  = {1'b0, opb_r[31:1]};
      end
      count_nxt = count_r - 6'd1;
      if (count_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      acc_nxt   = (req.op == OP_DIV) ? 64'd0 : {32'd0, req.init};
      work_nxt  = {15'd0, req.a};
      opb_nxt   = req.b;
      count_nxt = (req.op == OP_DIV) ? DIV_STEPS : MUL_STEPS;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
      op_r    <= OP_MUL;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
      if (!busy_r && req.start) begin
        op_r <= req.op;
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    work_r <= work_nxt;
    opb_r  <= opb_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = (op_r == OP_DIV) ? work_r : acc_r;

endmodule

@@ sv/tipping_bucket_rain_meter.sv @@
// Tipping-bucket rain meter.
// Input channel in_chan carries requests of mode (tip edge, read, clear) and a
// free-running microsecond stamp now_us. Result channel out_chan returns
// rate_mmh and depth_mm (signed Q.16, saturating) for each enabled read.
// Calibration registers sit on the APB port at byte address 4*index.
// Tip, clear, unused modes and disabled reads do not stall: the request is
// accepted and in_chan.ready stays high. An enabled read holds in_chan.ready
// low while one shared shift-add multiply / restoring divide unit runs: each
// multiply runs 16 steps, the divide 49 steps (49 quotient bits). A read runs
// the depth multiply and its calibration multiply; only when the rate is live
// does it add the rate numerator multiply, the divide and the rate calibration
// multiply before loading the result register.
// The result register decouples the channels: new requests are accepted while
// a finished result waits; a following read stalls before loading the
// register until the receiver has taken the previous result.
// Synchronous active-low reset clears the tip count, last tip time, last
// interval and result valid, and loads the register reset values.
module tipping_bucket_rain_meter (
  input  logic                         clk,
  input  logic                         rst_n,
  trm_in_if.sink                       in_chan,
  trm_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trm_pkg::ADDR_W-1:0]   paddr,
  input  logic [trm_pkg::DATA_W-1:0]   pwdata,
  output logic [trm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import trm_pkg::*;

  localparam logic signed [53:0] SAT_HI = 54'sd140737488355327;
  localparam logic signed [53:0] SAT_LO = -54'sd140737488355328;

  cfg_t     cfg;
  mdu_req_t mdu_req;
  mdu_sts_t mdu_sts;
  logic [63:0] mdu_res;

  state_t state_r, state_nxt;
  logic   first_r;

  logic [31:0] tip_count_r, last_tip_r, last_iv_r;
  logic        gate_r;
  logic [47:0] total_r, rate_r;
  logic        out_valid_r;
  logic [47:0] out_rate_r, out_total_r;

  logic        in_acc;
  logic [31:0] dt;
  logic        tip_ok;
  logic        gate;
  logic        out_load;
  logic        is_read;

  trm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trm_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .sts   (mdu_sts),
    .res   (mdu_res)
  );

  // drop the 12 scale fraction bits, add offset, saturate to 48 bits
  function automatic logic [47:0] calib(input logic [63:0] acc,
                                        input logic [31:0] ofs);
    logic signed [53:0] s;
    s = $signed({2'b00, acc[63:12]}) + $signed({{22{ofs[31]}}, ofs});
    if (s > SAT_HI) begin
      calib = SAT_HI[47:0];
    end else if (s < SAT_LO) begin
      calib = SAT_LO[47:0];
    end else begin
      calib = s[47:0];
    end
  endfunction

  // request decode
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign dt            = in_chan.now_us - last_tip_r;
  assign tip_ok        = (dt >= {12'd0, cfg.debounce_us});
  assign gate          = (last_iv_r != 32'd0) && (last_iv_r < HOUR_US) &&
                         ({1'b0, dt} <= {last_iv_r, 1'b0});
  assign is_read       = in_acc && (in_chan.mode == MODE_READ) && cfg.enable;
  assign out_load      = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (is_read) state_nxt = ST_TOT_RAW;
      ST_TOT_RAW:  if (mdu_sts.done) state_nxt = ST_TOT_CAL;
      ST_TOT_CAL:  if (mdu_sts.done) state_nxt = ST_TOT_FIX;
      ST_TOT_FIX:  state_nxt = gate_r ? ST_NUM : ST_OUT;
      ST_NUM:      if (mdu_sts.done) state_nxt = ST_DIV;
      ST_DIV:      if (mdu_sts.done) state_nxt = ST_RATE_CAL;
      ST_RATE_CAL: if (mdu_sts.done) state_nxt = ST_RATE_FIX;
      ST_RATE_FIX: state_nxt = ST_OUT;
      ST_OUT:      if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // unit requests per state
  always_comb begin
    mdu_req.start = 1'b0;
    mdu_req.op    = OP_MUL;
    mdu_req.a     = '0;
    mdu_req.b     = '0;
    mdu_req.init  = '0;
    case (state_r)
      ST_TOT_RAW: begin
        mdu_req.start = first_r;
        mdu_req.a     = {17'd0, tip_count_r};
        mdu_req.b     = {16'd0, cfg.mm_per_tip};
      end
      ST_TOT_CAL: begin
        mdu_req.start = first_r;
        mdu_req.a     = {1'b0, mdu_res[47:0]};
        mdu_req.b     = {16'd0, cfg.total_scale};
        mdu_req.init  = ROUND_HALF;
      end
      ST_NUM: begin
        mdu_req.start = first_r;
        mdu_req.a     = {17'd0, HOUR_US};
        mdu_req.b     = {16'd0, cfg.mm_per_tip};
        mdu_req.init  = {1'b0, last_iv_r[31:1]};
      end
      ST_DIV: begin
        mdu_req.start = first_r;
        mdu_req.op    = OP_DIV;
        mdu_req.a     = mdu_res[48:0];
        mdu_req.b     = last_iv_r;
      end
      ST_RATE_CAL: begin
        mdu_req.start = first_r;
        mdu_req.a     = {1'b0, mdu_res[47:0]};
        mdu_req.b     = {16'd0, cfg.rate_scale};
        mdu_req.init  = ROUND_HALF;
      end
      default: mdu_req.start = 1'b0;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);
    end
  end

  // gauge state: tips and clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_count_r <= '0;
      last_tip_r  <= '0;
      last_iv_r   <= '0;
    end else if (in_acc) begin
      if (in_chan.mode == MODE_TIP) begin
        if (tip_ok) begin
          last_iv_r   <= dt;
          last_tip_r  <= in_chan.now_us;
          tip_count_r <= tip_count_r + 32'd1;
        end
      end else if (in_chan.mode == MODE_CLEAR) begin
        tip_count_r <= '0;
        last_tip_r  <= '0;
        last_iv_r   <= '0;
      end
    end
  end

  // working results
  always_ff @(posedge clk) begin
    if (is_read) begin
      gate_r <= gate;
      rate_r <= '0;
    end
    if (state_r == ST_TOT_FIX) begin
      total_r <= calib(mdu_res, cfg.total_offset);
    end
    if (state_r == ST_RATE_FIX) begin
      rate_r <= calib(mdu_res, cfg.rate_offset);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_r  <= rate_r;
      out_total_r <= total_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.rate_mmh = out_rate_r;
  assign out_chan.depth_mm = out_total_r;

  // checks
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    is_read |=> (state_r == ST_TOT_RAW))
    else $error("enabled read did not start the sequence");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_req.start |-> !mdu_sts.busy)
    else $error("arithmetic unit started while busy");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.mode == MODE_CLEAR) |=>
      (tip_count_r == 32'd0 && last_iv_r == 32'd0 && last_tip_r == 32'd0))
    else $error("clear left gauge state");

  a_bounce: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.mode == MODE_TIP && !tip_ok) |=> $stable(tip_count_r))
    else $error("bounced tip changed the count");

  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_sts.done |-> (state_r == ST_TOT_RAW || state_r == ST_TOT_CAL ||
                      state_r == ST_NUM || state_r == ST_DIV ||
                      state_r == ST_RATE_CAL))
    else $error("arithmetic unit finished outside an operation state");

endmodule

@@ dv/tb_tipping_bucket_rain_meter.sv @@
module tb_tipping_bucket_rain_meter;
  import trm_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned MAX_IDLE = 13;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned PRINT_CAP = 40;
  localparam logic signed [65:0] OUT_HI = 66'sh7FFF_FFFF_FFFF;
  localparam logic signed [65:0] OUT_LO = -OUT_HI - 66'sd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_us;
  } meter_req_t;

  typedef struct packed {
    logic [47:0] rate;
    logic [47:0] total;
  } meter_reading_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  trm_in_if  in_if ();
  trm_out_if out_if ();

  tipping_bucket_rain_meter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // meter state and register copy used for prediction
  cfg_t        meter_cfg;
  logic [31:0] tips_seen;
  logic [31:0] last_tip_us;
  logic [31:0] last_gap_us;

  meter_req_t     req_backlog[$];
  meter_reading_t readings_due[$];

  int unsigned mismatches;
  int unsigned send_wait;
  int unsigned take_wait;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  logic        send_idle;
  logic        take_idle;
  logic        hold_kick;

  // stimulus shaping: tracks the tip timeline the requests are built on
  logic [31:0] gen_last;
  logic [31:0] gen_gap;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offset + scale * raw in Q4.12, saturated to 48 bits signed
  function automatic logic [47:0] apply_gain(logic [63:0] raw, logic [15:0] gain,
                                             logic signed [31:0] ofs);
    logic [63:0] scaled;
    logic signed [65:0] sum;
    scaled = (raw * 64'(gain) + 64'd2048) >> 12;
    sum = $signed({2'b00, scaled}) + $signed({{34{ofs[31]}}, ofs});
    if (sum > OUT_HI) sum = OUT_HI;
    if (sum < OUT_LO) sum = OUT_LO;
    return sum[47:0];
  endfunction

  // advance the meter by one accepted request, queue the reading it yields
  task automatic meter_step(logic [1:0] mode, logic [31:0] now);
    logic [31:0] dt;
    logic [63:0] num;
    logic [63:0] raw;
    meter_reading_t rd;
    dt = now - last_tip_us;
    case (mode)
      MODE_TIP: begin
        if (dt >= 32'(meter_cfg.debounce_us)) begin
          last_gap_us = dt;
          last_tip_us = now;
          tips_seen = tips_seen + 32'd1;
        end
      end
      MODE_CLEAR: begin
        tips_seen = '0;
        last_tip_us = '0;
        last_gap_us = '0;
      end
      MODE_READ: begin
        if (meter_cfg.enable) begin
          rd.rate = '0;
          // rate only while the last interval is fresh and under an hour
          if (last_gap_us != 0 && last_gap_us < HOUR_US &&
              {1'b0, dt} <= {last_gap_us, 1'b0}) begin
            num = 64'(meter_cfg.mm_per_tip) * 64'(HOUR_US);
            raw = (num + 64'(last_gap_us >> 1)) / 64'(last_gap_us);
            rd.rate = apply_gain(raw, meter_cfg.rate_scale, meter_cfg.rate_offset);
          end
          raw = 64'(tips_seen) * 64'(meter_cfg.mm_per_tip);
          rd.total = apply_gain(raw, meter_cfg.total_scale, meter_cfg.total_offset);
          readings_due.push_back(rd);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin : send_side
    meter_req_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_wait <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) meter_step(in_if.mode, in_if.now_us);
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_if.valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        nxt = req_backlog.pop_front();
        in_if.valid <= 1'b1;
        in_if.mode <= nxt.mode;
        in_if.now_us <= nxt.now_us;
        send_wait <= send_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : take_side
    meter_reading_t want;
    int unsigned wait_n;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      take_wait <= 0;
    end else begin
      wait_n = (take_wait != 0) ? take_wait - 1 : 0;
      if (out_if.valid && out_if.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("reading with none due", out_if.rate_mmh, '0);
        end else begin
          want = readings_due.pop_front();
          if (out_if.rate_mmh !== want.rate)
            report_mismatch("rate_mmh", out_if.rate_mmh, want.rate);
          if (out_if.depth_mm !== want.total)
            report_mismatch("depth_mm", out_if.depth_mm, want.total);
        end
        wait_n = take_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      take_wait <= wait_n;
      out_if.ready <= (wait_n == 0) && (hold_left == 0);
    end
  end

  // watchdog on cycles without any accepted request or reading
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_request(logic [1:0] mode, logic [31:0] now);
    meter_req_t r;
    r.mode = mode;
    r.now_us = now;
    req_backlog.push_back(r);
  endtask

  // mostly coherent tip/read timelines around debounce and rate-gate edges
  task automatic queue_random_items(int unsigned n);
    logic [31:0] deb;
    logic [31:0] dt;
    logic [31:0] lim;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      deb = 32'(meter_cfg.debounce_us);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0: dt = $urandom_range(0, deb);
          1: dt = deb;
          2: dt = (deb == 0) ? 32'd0 : deb - 32'd1;
          8: dt = $urandom;
          9: dt = HOUR_US - 32'd1 + $urandom_range(0, 2);
          default: dt = deb + $urandom_range(0, 3 * deb + 1000);
        endcase
        add_request(MODE_TIP, gen_last + dt);
        if (dt >= deb) begin
          gen_gap = dt;
          gen_last = gen_last + dt;
        end
      end else if (pick < 80) begin
        lim = (gen_gap > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : gen_gap << 1;
        case ($urandom_range(0, 5))
          0: dt = lim;
          1: dt = lim + 32'd1;
          2: dt = $urandom;
          default: dt = $urandom_range(0, lim);
        endcase
        add_request(MODE_READ, gen_last + dt);
      end else if (pick < 85) begin
        add_request(MODE_CLEAR, $urandom);
        gen_last = '0;
        gen_gap = '0;
      end else if (pick < 88) begin
        add_request(MODE_SPARE, $urandom);
      end else begin
        add_request(2'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  // wait until every request is taken and every reading is back
  task automatic settle();
    while (req_backlog.size() != 0 || in_if.valid || readings_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // two-phase register write, copy kept in step
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:       meter_cfg.enable = val[0];
      REG_DEBOUNCE_US:  meter_cfg.debounce_us = val[19:0];
      REG_MM_PER_TIP:   meter_cfg.mm_per_tip = val[15:0];
      REG_RATE_SCALE:   meter_cfg.rate_scale = val[15:0];
      REG_RATE_OFFSET:  meter_cfg.rate_offset = val;
      REG_TOTAL_SCALE:  meter_cfg.total_scale = val[15:0];
      REG_TOTAL_OFFSET: meter_cfg.total_offset = val;
      default: ;
    endcase
  endtask

  task automatic program_meter(logic en, logic [31:0] deb, logic [31:0] mm,
                               logic [31:0] r_scale, logic [31:0] r_ofs,
                               logic [31:0] t_scale, logic [31:0] t_ofs);
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_DEBOUNCE_US, deb);
    write_reg(REG_MM_PER_TIP, mm);
    write_reg(REG_RATE_SCALE, r_scale);
    write_reg(REG_RATE_OFFSET, r_ofs);
    write_reg(REG_TOTAL_SCALE, t_scale);
    write_reg(REG_TOTAL_OFFSET, t_ofs);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_TIP;
    in_if.now_us = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_kick = 1'b0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    mismatches = 0;
    meter_cfg.enable = RST_ENABLE;
    meter_cfg.debounce_us = RST_DEBOUNCE_US;
    meter_cfg.mm_per_tip = RST_MM_PER_TIP;
    meter_cfg.rate_scale = RST_RATE_SCALE;
    meter_cfg.rate_offset = '0;
    meter_cfg.total_scale = RST_TOTAL_SCALE;
    meter_cfg.total_offset = '0;
    tips_seen = '0;
    last_tip_us = '0;
    last_gap_us = '0;
    gen_last = '0;
    gen_gap = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: debounce edges, rate gate edges, wrap, clear, spare mode
    add_request(MODE_READ, 32'd0);
    add_request(MODE_TIP, 32'd100);
    add_request(MODE_TIP, 32'd6000);
    add_request(MODE_TIP, 32'd10999);
    add_request(MODE_TIP, 32'd11000);
    add_request(MODE_READ, 32'd21000);
    add_request(MODE_READ, 32'd21001);
    add_request(MODE_SPARE, 32'hFFFF_FFFF);
    add_request(MODE_TIP, 32'hFFFF_FFFF);
    add_request(MODE_READ, 32'hFFFF_FFFF);
    add_request(MODE_TIP, 32'h0000_1387);
    add_request(MODE_READ, 32'h0000_2000);
    add_request(MODE_CLEAR, 32'd0);
    add_request(MODE_READ, 32'd5);
    add_request(MODE_TIP, 32'd3599999999);
    add_request(MODE_READ, 32'd3600000050);
    add_request(MODE_TIP, 32'd2905032703);
    add_request(MODE_READ, 32'd2905032703);
    add_request(MODE_CLEAR, 32'hFFFF_FFFF);
    queue_random_items(230);
    settle();

    // receiver holds off while requests keep coming
    send_idle = 1'b0;
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    queue_random_items(40);
    settle();
    send_idle = 1'b1;

    // reads suppressed
    write_reg(REG_ENABLE, 32'd0);
    add_request(MODE_READ, gen_last);
    queue_random_items(60);
    settle();

    // upper extremes: zero debounce, zero and unit intervals, rate saturation
    program_meter(1'b1, 32'd0, 32'd65535, 32'd65535, 32'h7FFF_FFFF,
                  32'd65535, 32'h7FFF_FFFF);
    add_request(MODE_TIP, 32'd50);
    add_request(MODE_TIP, 32'd50);
    add_request(MODE_READ, 32'd50);
    add_request(MODE_TIP, 32'd51);
    add_request(MODE_READ, 32'd52);
    gen_last = 32'd51;
    gen_gap = 32'd1;
    take_idle = 1'b0;
    queue_random_items(80);
    settle();
    take_idle = 1'b1;

    // lower extremes: widest debounce, zero depth and gains, negative offsets
    program_meter(1'b1, 32'h000F_FFFF, 32'd0, 32'd0, 32'h8000_0000,
                  32'd0, 32'h8000_0000);
    queue_random_items(80);
    settle();

    // random settings, idling switched per phase
    for (int unsigned ph = 0; ph < 4; ph++) begin
      program_meter($urandom_range(0, 3) != 0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hF_FFFF)
                                                : $urandom_range(0, 20000),
                    $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom,
                    $urandom_range(0, 65535), $urandom);
      send_idle = ph[0];
      take_idle = ph[1];
      queue_random_items(100);
      settle();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
